FILE: rtl/core/plbu_pkg.sv
// ----------------------------------------------------------------------------
// plbu_pkg
// Shared types and codes for the price-level book update block: request and
// result items, the control word that runs along the cell chain, op and
// status codes.
// ----------------------------------------------------------------------------
package plbu_pkg;

	localparam int LEVELS_DEF = 64;
	localparam int PRICE_W    = 63;
	localparam int QTY_W      = 32;

	// operation codes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_MOD  = 2'd1;
	localparam logic [1:0] OP_REM  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// status codes
	localparam logic [2:0] STS_APPLIED     = 3'd0;
	localparam logic [2:0] STS_ADD_DUP     = 3'd1;
	localparam logic [2:0] STS_MOD_MISSING = 3'd2;
	localparam logic [2:0] STS_REM_MISSING = 3'd3;
	localparam logic [2:0] STS_FULL        = 3'd4;

	typedef struct packed {
		logic [1:0]               operation;
		logic                     is_bid;
		logic [PRICE_W-1:0]       price;
		logic signed [QTY_W-1:0]  quantity;
	} req_t;

	typedef struct packed {
		logic [2:0]               status;
		logic                     update_valid;
		logic [1:0]               upd_operation;
		logic                     upd_is_bid;
		logic [PRICE_W-1:0]       upd_price;
		logic signed [QTY_W-1:0]  upd_quantity;
	} rsp_t;

	// control word broadcast to every cell
	typedef struct packed {
		logic                     cmp;      // latch local price match
		logic                     add;      // lowest free cell takes the level
		logic                     clr;      // matching cell drops its level
		logic                     setq;     // matching cell takes new quantity
		logic                     is_bid;
		logic [PRICE_W-1:0]       price;
		logic signed [QTY_W-1:0]  quantity;
	} ctl_t;

endpackage

FILE: rtl/core/plbu_cell.sv
// ----------------------------------------------------------------------------
// plbu_cell
// One level slot of both sides. Compares its own price against the request,
// passes the free-slot chain on to its neighbor and applies add, clear or
// quantity updates.
// ----------------------------------------------------------------------------
module plbu_cell
	import plbu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctl_t  ctl,
	input  logic  free_in,
	output logic  free_out,
	output logic  hit
);

	logic                     bid_used_q, ask_used_q;
	logic [PRICE_W-1:0]       bid_price_q, ask_price_q;
	logic signed [QTY_W-1:0]  bid_qty_q, ask_qty_q;
	logic                     hit_q;

	logic                     used_side;
	logic [PRICE_W-1:0]       price_side;
	logic                     take;

	// select the side named by the request
	assign used_side  = ctl.is_bid ? bid_used_q : ask_used_q;
	assign price_side = ctl.is_bid ? bid_price_q : ask_price_q;

	// lowest free slot: free here and nothing free below
	assign take     = !free_in && !used_side;
	assign free_out = free_in || !used_side;
	assign hit      = hit_q;

	// latch local match
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_q <= used_side && (price_side == ctl.price);
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_used_q <= 1'b0;
			ask_used_q <= 1'b0;
		end else begin
			if (ctl.add && take) begin
				if (ctl.is_bid) bid_used_q <= 1'b1;
				else            ask_used_q <= 1'b1;
			end else if (ctl.clr && hit_q) begin
				if (ctl.is_bid) bid_used_q <= 1'b0;
				else            ask_used_q <= 1'b0;
			end
		end
	end

	// level payload
	always_ff @(posedge clk) begin
		if (ctl.add && take) begin
			if (ctl.is_bid) begin
				bid_price_q <= ctl.price;
				bid_qty_q   <= ctl.quantity;
			end else begin
				ask_price_q <= ctl.price;
				ask_qty_q   <= ctl.quantity;
			end
		end else if (ctl.setq && hit_q) begin
			if (ctl.is_bid) bid_qty_q <= ctl.quantity;
			else            ask_qty_q <= ctl.quantity;
		end
	end

endmodule

FILE: rtl/core/price_level_book_update_top.sv
// ----------------------------------------------------------------------------
// price_level_book_update_top
// Bid and ask price-level tables held in a chain of cells, one level slot per
// cell. Each request item asks to add, modify or remove a level and gives one
// result item with a status code and the echoed update.
// ----------------------------------------------------------------------------
// Sequence: compare state (cells latch their price match), then update state
// (free-slot chain); the result is registered as the update state completes,
// which waits while the result is stalled, and a new request is taken then.
// Reset: asynchronous, clears all used bits and the handshake state; level
// prices and quantities are not reset.
module price_level_book_update_top
	import plbu_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0]        state_q;
	req_t              req_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	ctl_t              ctl;
	logic [LEVELS:0]   free_chain;
	logic [LEVELS-1:0] hit_vec;
	logic              any_hit;
	logic              full;
	logic              upd_go;
	logic              req_acc;
	logic [2:0]        status;
	logic              do_add, do_clr, do_setq;
	logic              qty_del;

	// cell chain
	assign free_chain[0] = 1'b0;
	for (genvar i = 0; i < LEVELS; i++) begin : g_cell
		plbu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.free_in  (free_chain[i]),
			.free_out (free_chain[i+1]),
			.hit      (hit_vec[i])
		);
	end

	assign any_hit = |hit_vec;
	assign full    = !free_chain[LEVELS];
	assign qty_del = (req_q.quantity == '0) || req_q.quantity[QTY_W-1];

	// decide outcome of the current request
	always_comb begin
		status  = STS_REM_MISSING;
		do_add  = 1'b0;
		do_clr  = 1'b0;
		do_setq = 1'b0;
		unique case (req_q.operation)
			OP_ADD: begin
				if (any_hit) begin
					status = STS_ADD_DUP;
				end else if (full) begin
					status = STS_FULL;
				end else begin
					status = STS_APPLIED;
					do_add = 1'b1;
				end
			end
			OP_MOD: begin
				if (!any_hit) begin
					status = STS_MOD_MISSING;
				end else begin
					status  = STS_APPLIED;
					do_clr  = qty_del;
					do_setq = !qty_del;
				end
			end
			OP_REM: begin
				if (!any_hit) begin
					status = STS_REM_MISSING;
				end else begin
					status = STS_APPLIED;
					do_clr = 1'b1;
				end
			end
			default: begin
				status = STS_REM_MISSING;
			end
		endcase
	end

	// advance when the result slot is free or being drained
	assign upd_go  = (state_q == S_UPD) && (!rsp_valid_q || !rsp_stall);
	assign req_stall = !((state_q == S_IDLE) || upd_go);
	assign req_acc = req_valid && !req_stall;

	// drive the cell control word
	always_comb begin
		ctl.cmp      = (state_q == S_CMP);
		ctl.add      = upd_go && do_add;
		ctl.clr      = upd_go && do_clr;
		ctl.setq     = upd_go && do_setq;
		ctl.is_bid   = req_q.is_bid;
		ctl.price    = req_q.price;
		ctl.quantity = req_q.quantity;
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req_acc) state_q <= S_CMP;
				S_CMP:  state_q <= S_UPD;
				S_UPD:  if (upd_go) state_q <= req_acc ? S_CMP : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold request, load result
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		if (upd_go) begin
			rsp_q.status        <= status;
			rsp_q.update_valid  <= (status == STS_APPLIED);
			rsp_q.upd_operation <= (req_q.operation == OP_NONE) ? OP_ADD : req_q.operation;
			rsp_q.upd_is_bid    <= req_q.is_bid;
			rsp_q.upd_price     <= req_q.price;
			rsp_q.upd_quantity  <= req_q.quantity;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// prices are unique per side, so at most one cell matches
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $onehot0(hit_vec))
		else $error("more than one cell matches the request price");

	// an add only goes ahead with a free slot in the chain
	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.add |-> !full && !any_hit)
		else $error("add issued without a free slot or with a duplicate");

	// a new result only follows an update cycle
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_UPD)
		else $error("result raised outside the update cycle");

	// published flag tracks the applied status
	a_upd_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.update_valid == (rsp_q.status == STS_APPLIED)))
		else $error("update_valid disagrees with status");

endmodule

FILE: tb/sv/price_level_book_update_checker.sv
// ----------------------------------------------------------------------------
// price_level_book_update_checker
// Watches the request and result channels of the price-level book update
// block, keeps its own bid and ask level tables, predicts the result of each
// accepted request item and compares every accepted result item against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module price_level_book_update_checker
	import plbu_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  logic  req_stall,
	input  req_t  req,
	input  logic  rsp_valid,
	input  logic  rsp_stall,
	input  rsp_t  rsp,
	output int    pending,
	output int    mismatches
);

	localparam int REPORT_MAX = 10;

	// side index 1 is bid, 0 is ask
	logic                    lvl_used  [2][LEVELS];
	logic [PRICE_W-1:0]      lvl_price [2][LEVELS];
	logic signed [QTY_W-1:0] lvl_qty   [2][LEVELS];

	rsp_t expected_rsp_q [$];
	int   fail_cnt = 0;

	assign mismatches = fail_cnt;

	// count a failure, report only the first few
	function automatic void note_failure(input string msg);
		fail_cnt++;
		if (fail_cnt <= REPORT_MAX)
			$display("%0t ns: %s", $realtime, msg);
	endfunction

	// apply one request to the level tables and return the result it gives
	function automatic rsp_t predict_book_result(input req_t r);
		rsp_t       o;
		int         side;
		int         hit;
		int         slot;
		int         i;
		logic [2:0] st;
		side = r.is_bid ? 1 : 0;
		hit  = -1;
		slot = -1;
		for (i = 0; i < LEVELS; i++) begin
			if (hit < 0 && lvl_used[side][i] && lvl_price[side][i] == r.price)
				hit = i;
			if (slot < 0 && !lvl_used[side][i])
				slot = i;
		end
		case (r.operation)
			OP_ADD: begin
				if (hit >= 0) begin
					st = STS_ADD_DUP;
				end else if (slot < 0) begin
					st = STS_FULL;
				end else begin
					lvl_used[side][slot]  = 1'b1;
					lvl_price[side][slot] = r.price;
					lvl_qty[side][slot]   = r.quantity;
					st = STS_APPLIED;
				end
			end
			OP_MOD: begin
				if (hit < 0) begin
					st = STS_MOD_MISSING;
				end else begin
					// zero or negative quantity drops the level
					if ($signed(r.quantity) <= 0)
						lvl_used[side][hit] = 1'b0;
					else
						lvl_qty[side][hit] = r.quantity;
					st = STS_APPLIED;
				end
			end
			OP_REM: begin
				if (hit < 0) begin
					st = STS_REM_MISSING;
				end else begin
					lvl_used[side][hit] = 1'b0;
					st = STS_APPLIED;
				end
			end
			default: begin
				st = STS_REM_MISSING;
			end
		endcase
		o.status        = st;
		o.update_valid  = (st == STS_APPLIED);
		o.upd_operation = (r.operation inside {OP_ADD, OP_MOD, OP_REM}) ? r.operation : OP_ADD;
		o.upd_is_bid    = r.is_bid;
		o.upd_price     = r.price;
		o.upd_quantity  = r.quantity;
		return o;
	endfunction

	// check results first, then record the prediction for a new request
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		int   s;
		int   i;
		if (!arst_n) begin
			for (s = 0; s < 2; s++)
				for (i = 0; i < LEVELS; i++)
					lvl_used[s][i] = 1'b0;
			expected_rsp_q.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					note_failure($sformatf("unexpected result item st=%0d px=%h",
						rsp.status, rsp.upd_price));
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.status !== exp_rsp.status ||
					    rsp.update_valid !== exp_rsp.update_valid ||
					    rsp.upd_operation !== exp_rsp.upd_operation ||
					    rsp.upd_is_bid !== exp_rsp.upd_is_bid ||
					    rsp.upd_price !== exp_rsp.upd_price ||
					    rsp.upd_quantity !== exp_rsp.upd_quantity)
						note_failure($sformatf({"result mismatch: exp st=%0d uv=%0b op=%0d ",
							"bid=%0b px=%h qty=%0d, got st=%0d uv=%0b op=%0d bid=%0b ",
							"px=%h qty=%0d"},
							exp_rsp.status, exp_rsp.update_valid, exp_rsp.upd_operation,
							exp_rsp.upd_is_bid, exp_rsp.upd_price,
							$signed(exp_rsp.upd_quantity),
							rsp.status, rsp.update_valid, rsp.upd_operation,
							rsp.upd_is_bid, rsp.upd_price, $signed(rsp.upd_quantity)));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q = {expected_rsp_q, predict_book_result(req)};
			pending <= expected_rsp_q.size();
		end
	end

endmodule

FILE: tb/sv/price_level_book_update_top_tb.sv
// ----------------------------------------------------------------------------
// price_level_book_update_top_tb
// Drives request items into the price-level book update block: a directed
// opening over the special cases, then random phases of level churn, table
// fill, table clear and raw noise on both sides, with random idling on both
// channels, one long result hold-off and drain pauses. A checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module price_level_book_update_top_tb;
	import plbu_pkg::*;

	localparam int               TOTAL_ITEMS = 1670;
	localparam int               QUIET_LIMIT = 2000;
	localparam int               HOLD_CYCLES = 300;
	localparam int               FILL_SPAN   = 72;
	localparam int               POOL_SIZE   = 24;
	localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
	localparam logic [QTY_W-1:0] QTY_MAX     = 32'h7FFF_FFFF;
	localparam logic [QTY_W-1:0] QTY_MIN     = 32'h8000_0000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int   pending;
	int   fail_count;
	bit   calm        = 1'b0;
	int   hold_ticket = 0;
	int   hold_served = 0;
	int   hold_left   = 0;
	int   quiet_cycles = 0;
	int   items_sent  = 0;
	int   pass_no     = 0;

	logic [PRICE_W-1:0] price_pool [POOL_SIZE];

	price_level_book_update_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	price_level_book_update_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.pending    (pending),
		.mismatches (fail_count)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: random stall, long hold-off on request, none while calm
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_ticket != hold_served) begin
			rsp_stall   <= 1'b1;
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_ticket;
		end else begin
			rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("price_level_book_update_top regression: fail");
			$finish;
		end
	end

	function automatic logic [PRICE_W-1:0] pick_price();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[PRICE_W-1:0];
	endfunction

	// mix of zero, negative, extreme and positive quantities
	function automatic logic [QTY_W-1:0] pick_quantity();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			return '0;
		else if (roll < 27)
			return {1'b1, 31'($urandom)};
		else if (roll < 30)
			return (roll == 28) ? QTY_MAX : QTY_MIN;
		else if (roll < 40)
			return $urandom_range(1, 1000);
		else
			return $urandom;
	endfunction

	// offer one item, idling first at random, and hold it until accepted
	task automatic send_update(input logic [1:0] op, input logic side,
			input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] qty);
		req_t item;
		item.operation = op;
		item.is_bid    = side;
		item.price     = px;
		item.quantity  = qty;
		if (!calm) begin
			while ($urandom_range(0, 99) < 30) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	// stop offering until every predicted result has come back
	task automatic wait_book_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mixed traffic on a small price pool so most items hit live levels
	task automatic run_churn(input int count);
		int          n;
		int          roll;
		logic [1:0]  op;
		for (n = 0; n < POOL_SIZE; n++)
			price_pool[n] = pick_price();
		price_pool[0] = '0;
		price_pool[1] = PRICE_MAX;
		for (n = 0; n < count; n++) begin
			if (pass_no == 0 && n == 20)
				hold_ticket <= hold_ticket + 1;
			roll = $urandom_range(0, 99);
			if (roll < 40)
				op = OP_ADD;
			else if (roll < 65)
				op = OP_MOD;
			else if (roll < 92)
				op = OP_REM;
			else
				op = OP_NONE;
			if (roll >= 96)
				send_update(op, 1'($urandom_range(0, 1)), pick_price(), pick_quantity());
			else
				send_update(op, 1'($urandom_range(0, 1)),
					price_pool[$urandom_range(0, POOL_SIZE - 1)], pick_quantity());
		end
	endtask

	// add a run of new prices on one side until it overflows
	task automatic run_fill(input logic side, input logic [PRICE_W-1:0] base);
		int k;
		for (k = 0; k < FILL_SPAN; k++) begin
			if ($urandom_range(0, 99) < 20)
				send_update(2'($urandom_range(0, 2)), !side,
					price_pool[$urandom_range(0, POOL_SIZE - 1)], pick_quantity());
			send_update(OP_ADD, side, base + PRICE_W'(k), pick_quantity());
		end
	endtask

	// drop the run again by remove or by modify to zero or below
	task automatic run_clear(input logic side, input logic [PRICE_W-1:0] base);
		int k;
		int roll;
		for (k = FILL_SPAN - 1; k >= 0; k--) begin
			roll = $urandom_range(0, 99);
			if (roll < 10)
				send_update(OP_MOD, side, base + PRICE_W'(k), $urandom_range(1, 500));
			if (roll < 50)
				send_update(OP_REM, side, base + PRICE_W'(k), pick_quantity());
			else if (roll < 75)
				send_update(OP_MOD, side, base + PRICE_W'(k), '0);
			else
				send_update(OP_MOD, side, base + PRICE_W'(k), {1'b1, 31'($urandom)});
		end
	endtask

	// raw random fields, including the unused operation code
	task automatic run_noise(input int count);
		int n;
		for (n = 0; n < count; n++)
			send_update(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				($urandom_range(0, 1) != 0) ? pick_price()
					: price_pool[$urandom_range(0, POOL_SIZE - 1)],
				$urandom);
	endtask

	initial begin
		logic [PRICE_W-1:0] fill_base;
		logic               fill_side;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: extremes and each special case
		send_update(OP_ADD,  1'b1, '0,        QTY_MAX);
		send_update(OP_ADD,  1'b0, PRICE_MAX, QTY_MIN);    // negative add kept
		send_update(OP_ADD,  1'b1, '0,        32'd5);      // duplicate
		send_update(OP_MOD,  1'b1, '0,        32'd100);
		send_update(OP_MOD,  1'b0, PRICE_MAX, '0);         // zero deletes
		send_update(OP_MOD,  1'b0, PRICE_MAX, 32'd1);      // now missing
		send_update(OP_ADD,  1'b0, 63'd5,     '0);         // zero add kept
		send_update(OP_MOD,  1'b0, 63'd5,     32'hFFFF_FFFF); // negative deletes
		send_update(OP_REM,  1'b1, '0,        32'd7);
		send_update(OP_REM,  1'b1, '0,        32'd7);      // remove missing
		send_update(OP_NONE, 1'b1, PRICE_MAX, QTY_MAX);
		send_update(OP_NONE, 1'b0, '0,        '0);
		send_update(OP_ADD,  1'b1, 63'd12345, 32'd10);
		send_update(OP_ADD,  1'b0, 63'd12345, 32'd20);     // same price, other side
		send_update(OP_REM,  1'b0, 63'd12345, '0);
		send_update(OP_MOD,  1'b1, 63'd12345, QTY_MIN);
		send_update(OP_MOD,  1'b1, PRICE_MAX, QTY_MAX);    // modify missing
		send_update(OP_ADD,  1'b1, PRICE_MAX, 32'd1);
		send_update(OP_REM,  1'b0, PRICE_MAX, 32'd1);      // wrong side
		send_update(OP_REM,  1'b1, PRICE_MAX, 32'd1);
		wait_book_drained();

		// random phases, each followed by a drain pause
		while (items_sent < TOTAL_ITEMS) begin
			calm      <= (pass_no == 4);
			fill_side = ((pass_no / 4) % 2) != 0;
			case (pass_no % 4)
				0: begin
					run_churn(150);
				end
				1: begin
					fill_base = pick_price();
					run_fill(fill_side, fill_base);
				end
				2: begin
					run_clear(fill_side, fill_base);
				end
				default: begin
					run_noise(60);
				end
			endcase
			wait_book_drained();
			pass_no++;
		end

		// let any stray result show up before the verdict
		calm <= 1'b0;
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("price_level_book_update_top regression: pass");
		else
			$display("price_level_book_update_top regression: fail");
		$finish;
	end

endmodule
